/* hw/rtl/mpu_pkg.sv */
`default_nettype none
package mpu_pkg;

    localparam int POP_MAX    = 1024;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int MAX_GROUPS = 64;
    localparam int GRP_W      = 6;
    localparam int LGRP_W     = GRP_W + 1;
    localparam int MAX_STRAT  = 4;
    localparam int STRAT_W    = 2;
    localparam int ROW_W      = CNT_W * MAX_STRAT;
    localparam int POP_W      = GRP_W + STRAT_W;
    localparam int PAY_W      = 16;
    localparam int LUT_DEPTH  = 256;
    localparam int LUT_W      = 8;
    localparam int PROB_W     = 17;
    localparam int HALF_RANGE = 524288;
    localparam int ACC_W      = 30;
    localparam int X_W        = 47;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_REDRAW  = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_LOADED  = 2'd3;

    localparam logic [2:0] CFG_ROW0  = 3'd0;
    localparam logic [2:0] CFG_ROW1  = 3'd1;
    localparam logic [2:0] CFG_ROW2  = 3'd2;
    localparam logic [2:0] CFG_ROW3  = 3'd3;
    localparam logic [2:0] CFG_SCALE = 3'd4;
    localparam logic [2:0] CFG_GSIZE = 3'd5;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  strategy;
        logic [9:0]  first_index;
        logic [9:0]  second_index;
        logic [15:0] uniform_draw;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  changed_index;
        logic [1:0]  new_strategy;
        logic [10:0] strategy_total;
        logic        fixated;
    } t_out_item;

    typedef logic [LUT_DEPTH-1:0][PROB_W-1:0] t_lut;

    // shift-subtract quotient, used only while building the table
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned fermi_at(longint c);
        longint unsigned t;
        longint unsigned u;
        longint unsigned term;
        longint          sum;
        longint unsigned e;
        longint unsigned p;
        longint unsigned one;
        one  = 64'd1073741824;
        t    = (c < 0) ? longint'(-c) : longint'(c);
        u    = t << 10;
        term = one;
        sum  = longint'(one);
        for (int k = 1; k <= 10; k++) begin
            term = udiv((term * u) >> 30, 64'(k));
            if ((k & 1) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        e = longint'(sum);
        for (int k = 0; k < 4; k++) e = (e * e) >> 30;
        p = udiv((e << 16) + ((one + e) >> 1), one + e);
        return (c < 0) ? (64'd65536 - p) : p;
    endfunction

    function automatic t_lut fermi_table();
        t_lut   tab;
        longint center;
        for (int b = 0; b < LUT_DEPTH; b++) begin
            center = -longint'(HALF_RANGE)
                + ((2 * longint'(b) + 1) * longint'(HALF_RANGE)) / LUT_DEPTH;
            tab[b] = PROB_W'(fermi_at(center));
        end
        return tab;
    endfunction

    localparam t_lut FERMI_LUT = fermi_table();

endpackage
`default_nettype wire

/* hw/rtl/mpu_ram.sv */
`default_nettype none
module mpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/mpu_fermi.sv */
`default_nettype none
module mpu_fermi (
    input  wire logic                               i_clk,
    input  wire logic signed [mpu_pkg::X_W-1:0]     i_x,
    output logic             [mpu_pkg::PROB_W-1:0]  o_prob
);
    // clamp to the table span, then bin = (x + half) * depth / 2^20
    logic [19:0]                   off;
    logic [32:0]                   scaled;
    logic [mpu_pkg::LUT_W-1:0]     bin;

    always_comb begin
        off    = i_x[19:0] + 20'(mpu_pkg::HALF_RANGE);
        scaled = 33'(off) * 33'(mpu_pkg::LUT_DEPTH);
        if (i_x < -(mpu_pkg::X_W)'(mpu_pkg::HALF_RANGE)) bin = '0;
        else if (i_x >= (mpu_pkg::X_W)'(mpu_pkg::HALF_RANGE))
            bin = mpu_pkg::LUT_W'(mpu_pkg::LUT_DEPTH - 1);
        else bin = scaled[20 +: mpu_pkg::LUT_W];
    end

    always_ff @(posedge i_clk) begin
        o_prob <= mpu_pkg::FERMI_LUT[bin];
    end
endmodule
`default_nettype wire

/* hw/rtl/moran_pairwise_update_step.sv */
// Pairwise-comparison (Fermi rule) update of a grouped population.
// Input channel (i_in_valid / o_in_stall / i_in_data): a load item appends
// one individual; a step item names two individuals and a uniform draw.
// A transfer happens on a rising edge with valid high and stall low.
// Output channel (o_out_valid / i_out_stall / o_out_data): one result per
// item, held in an output register until the receiver takes it.
// Items are handled one at a time by a sequencer around two memories:
// the population store and the per-group count rows.
// Loads, out-of-range items and same-strategy redraws end early; a full
// update does two population reads, two row reads, a multiply-accumulate
// for both fitness values, the scale multiply, the Fermi table lookup,
// write-back and the output load. A new item is taken once the last result
// has left the sequencer, also while it still waits in the output register;
// the new item's result is then held in the sequencer until that register is free.
// Reset (i_rst_n low, synchronous) empties the population, clears totals
// and group count rows (row valid bits), and restores scale 256, group 2.
// Configuration writes through i_cfg_we / i_cfg_idx / i_cfg_data are for
// the user to make only when idle; the block itself does not enforce this.
`default_nettype none
module moran_pairwise_update_step (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire mpu_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output mpu_pkg::t_out_item       o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [63:0]         i_cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_P1   = 4'd2;
    localparam logic [3:0] S_P2   = 4'd3;
    localparam logic [3:0] S_R1   = 4'd4;
    localparam logic [3:0] S_R2   = 4'd5;
    localparam logic [3:0] S_MAC  = 4'd6;
    localparam logic [3:0] S_XMUL = 4'd7;
    localparam logic [3:0] S_FERM = 4'd8;
    localparam logic [3:0] S_WB   = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    localparam int CW = mpu_pkg::CNT_W;
    localparam int SW = mpu_pkg::STRAT_W;
    localparam int GW = mpu_pkg::GRP_W;

    // configuration
    logic [63:0] r_payoff [mpu_pkg::MAX_STRAT];
    logic [15:0] r_scale;
    logic [10:0] r_gsize;

    // sequencer and counters
    logic [3:0]                   r_state, n_state;
    logic [CW-1:0]                r_load_pos;
    logic [mpu_pkg::LGRP_W-1:0]   r_load_grp;
    logic [CW-1:0]                r_off;
    logic [CW-1:0]                r_tot [mpu_pkg::MAX_STRAT];
    logic [mpu_pkg::MAX_GROUPS-1:0] r_row_valid;

    // working registers
    mpu_pkg::t_in_item            r_item;
    logic [SW-1:0]                r_s1, r_s2;
    logic [GW-1:0]                r_g1, r_g2;
    logic [mpu_pkg::ROW_W-1:0]    r_row1, r_row2;
    logic [3:0]                   r_cnt;
    logic signed [27:0]           r_prod;
    logic                         r_neg;
    logic signed [mpu_pkg::ACC_W-1:0] r_acc;
    logic signed [mpu_pkg::X_W-1:0]   r_x;
    mpu_pkg::t_out_item           r_res;
    mpu_pkg::t_out_item           r_out;
    logic                         r_out_valid;

    // memory ports
    logic                         pop_we, pop_re;
    logic [mpu_pkg::IDX_W-1:0]    pop_waddr, pop_raddr;
    logic [mpu_pkg::POP_W-1:0]    pop_wdata, pop_rdata;
    logic                         row_we, row_re;
    logic [GW-1:0]                row_waddr, row_raddr;
    logic [mpu_pkg::ROW_W-1:0]    row_wdata, row_rdata, row_now;
    logic [mpu_pkg::PROB_W-1:0]   prob;

    mpu_ram #(.WIDTH(mpu_pkg::POP_W), .DEPTH(mpu_pkg::POP_MAX)) u_pop (
        .i_clk(i_clk), .i_we(pop_we), .i_waddr(pop_waddr), .i_wdata(pop_wdata),
        .i_re(pop_re), .i_raddr(pop_raddr), .o_rdata(pop_rdata)
    );

    mpu_ram #(.WIDTH(mpu_pkg::ROW_W), .DEPTH(mpu_pkg::MAX_GROUPS)) u_rows (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(row_waddr), .i_wdata(row_wdata),
        .i_re(row_re), .i_raddr(row_raddr), .o_rdata(row_rdata)
    );

    mpu_fermi u_fermi (.i_clk(i_clk), .i_x(r_x), .o_prob(prob));

    // move one count from strategy lose to strategy win (dec low skips the decrement)
    function automatic logic [mpu_pkg::ROW_W-1:0] row_move(
        input logic [mpu_pkg::ROW_W-1:0] row,
        input logic                      dec,
        input logic [SW-1:0]             lose,
        input logic [SW-1:0]             win
    );
        logic [mpu_pkg::ROW_W-1:0] r;
        r = row;
        if (dec && r[CW*lose +: CW] != '0) r[CW*lose +: CW] = r[CW*lose +: CW] - 1'b1;
        r[CW*win +: CW] = r[CW*win +: CW] + 1'b1;
        return r;
    endfunction

    logic                 accept;
    logic                 out_free;
    logic                 load_ok;
    logic                 range_ok;
    logic [10:0]          gs;
    logic [CW-1:0]        n_off;
    logic                 first_wins;
    logic [SW-1:0]        win_s, lose_s;
    logic [CW-1:0]        n_tot [mpu_pkg::MAX_STRAT];
    logic                 tot_we;
    logic [SW-1:0]        mac_s;
    logic [CW-1:0]        mac_c;
    logic [mpu_pkg::ROW_W-1:0] mac_row;
    logic [1:0]           mac_k;
    logic signed [27:0]   mac_prod;
    logic                 fix_now;
    logic [GW-1:0]        row_raddr_q;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign gs         = (r_gsize < 11'd2) ? 11'd2 : r_gsize;
    assign load_ok    = (r_load_pos < CW'(mpu_pkg::POP_MAX))
                     && (r_load_grp < mpu_pkg::LGRP_W'(mpu_pkg::MAX_GROUPS))
                     && ({1'b0, i_in_data.strategy} < 3'(mpu_pkg::MAX_STRAT));
    assign range_ok   = ({1'b0, i_in_data.first_index} < r_load_pos)
                     && ({1'b0, i_in_data.second_index} < r_load_pos);
    assign first_wins = {1'b0, r_item.uniform_draw} < prob;
    assign win_s      = first_wins ? r_s2 : r_s1;
    assign lose_s     = first_wins ? r_s1 : r_s2;
    assign row_now    = r_row_valid[row_raddr_q] ? row_rdata : '0;

    // row address of the read in flight, for masking rows never written
    always_ff @(posedge i_clk) begin
        if (row_re) row_raddr_q <= row_raddr;
    end

    // fitness term: other-member count times payoff, both individuals in turn
    always_comb begin
        mac_k   = r_cnt[1:0];
        mac_s   = r_cnt[2] ? r_s2 : r_s1;
        mac_row = r_cnt[2] ? r_row2 : r_row1;
        mac_c   = mac_row[CW*mac_k +: CW];
        if (mac_k == mac_s && mac_c != '0) mac_c = mac_c - 1'b1;
        mac_prod = $signed({1'b0, mac_c}) * $signed(r_payoff[mac_s][16*mac_k +: 16]);
    end

    always_comb begin
        fix_now = 1'b0;
        for (int k = 0; k < mpu_pkg::MAX_STRAT; k++)
            if (r_tot[k] == r_load_pos) fix_now = 1'b1;
        if (r_load_pos == '0) fix_now = 1'b0;
    end

    always_comb begin
        n_state   = r_state;
        pop_we    = 1'b0;
        pop_waddr = r_load_pos[mpu_pkg::IDX_W-1:0];
        pop_wdata = {r_load_grp[GW-1:0], i_in_data.strategy};
        pop_re    = 1'b0;
        pop_raddr = i_in_data.first_index;
        row_we    = 1'b0;
        row_waddr = r_load_grp[GW-1:0];
        row_wdata = '0;
        row_re    = 1'b0;
        row_raddr = r_load_grp[GW-1:0];
        n_off     = r_off + 1'b1;
        tot_we    = 1'b0;
        for (int k = 0; k < mpu_pkg::MAX_STRAT; k++) n_tot[k] = r_tot[k];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_in_data.cmd) begin
                        if (load_ok) begin
                            pop_we  = 1'b1;
                            row_re  = 1'b1;
                            n_state = S_LOAD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else if (range_ok) begin
                        pop_re  = 1'b1;
                        n_state = S_P1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LOAD: begin
                // write back to the group that was read; the load group may have advanced
                row_we    = 1'b1;
                row_waddr = row_raddr_q;
                row_wdata = row_move(row_now, 1'b0, r_item.strategy, r_item.strategy);
                tot_we    = 1'b1;
                n_tot[r_item.strategy] = r_tot[r_item.strategy] + 1'b1;
                n_state   = S_DONE;
            end
            S_P1: begin
                pop_re    = 1'b1;
                pop_raddr = r_item.second_index;
                n_state   = S_P2;
            end
            S_P2: begin
                if (pop_rdata[SW-1:0] == r_s1) begin
                    n_state = S_DONE;
                end else begin
                    row_re    = 1'b1;
                    row_raddr = r_g1;
                    n_state   = S_R1;
                end
            end
            S_R1: begin
                row_re    = 1'b1;
                row_raddr = r_g2;
                n_state   = S_R2;
            end
            S_R2: n_state = S_MAC;
            S_MAC: begin
                if (r_cnt == 4'd8) n_state = S_XMUL;
            end
            S_XMUL: n_state = S_FERM;
            S_FERM: n_state = S_WB;
            S_WB: begin
                // the loser takes the winner's strategy
                pop_we    = 1'b1;
                pop_waddr = first_wins ? r_item.first_index : r_item.second_index;
                pop_wdata = {first_wins ? r_g1 : r_g2, win_s};
                row_we    = 1'b1;
                row_waddr = first_wins ? r_g1 : r_g2;
                row_wdata = row_move(first_wins ? r_row1 : r_row2, 1'b1, lose_s, win_s);
                tot_we    = 1'b1;
                if (r_tot[lose_s] != '0) n_tot[lose_s] = r_tot[lose_s] - 1'b1;
                n_tot[win_s] = r_tot[win_s] + 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load_pos  <= '0;
            r_load_grp  <= '0;
            r_off       <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
            r_scale     <= 16'd256;
            r_gsize     <= 11'd2;
            for (int k = 0; k < mpu_pkg::MAX_STRAT; k++) begin
                r_tot[k]    <= '0;
                r_payoff[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mpu_pkg::CFG_ROW0:  r_payoff[0] <= i_cfg_data;
                    mpu_pkg::CFG_ROW1:  r_payoff[1] <= i_cfg_data;
                    mpu_pkg::CFG_ROW2:  r_payoff[2] <= i_cfg_data;
                    mpu_pkg::CFG_ROW3:  r_payoff[3] <= i_cfg_data;
                    mpu_pkg::CFG_SCALE: r_scale     <= i_cfg_data[15:0];
                    mpu_pkg::CFG_GSIZE: r_gsize     <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (r_state == S_IDLE && accept && !i_in_data.cmd && load_ok) begin
                // advance load position and group counter
                r_load_pos <= r_load_pos + 1'b1;
                if (n_off >= gs) begin
                    r_off      <= '0;
                    r_load_grp <= r_load_grp + 1'b1;
                end else begin
                    r_off <= n_off;
                end
            end
            if (row_we) r_row_valid[row_waddr] <= 1'b1;
            if (tot_we) begin
                for (int k = 0; k < mpu_pkg::MAX_STRAT; k++) r_tot[k] <= n_tot[k];
            end
            // load a finished result, hold a stalled one, drop a taken one
            r_out_valid <= (r_state == S_DONE && out_free) || (r_out_valid && i_out_stall);
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= i_in_data;
                if (!i_in_data.cmd && load_ok) begin
                    r_res <= '{status: mpu_pkg::ST_LOADED,
                               changed_index: r_load_pos[mpu_pkg::IDX_W-1:0],
                               new_strategy: i_in_data.strategy,
                               strategy_total: '0, fixated: 1'b0};
                end else begin
                    r_res <= '{status: mpu_pkg::ST_RANGE, changed_index: '0,
                               new_strategy: '0, strategy_total: '0, fixated: 1'b0};
                end
            end
            S_LOAD: r_res.strategy_total <= n_tot[r_item.strategy];
            S_P1: begin
                r_s1 <= pop_rdata[SW-1:0];
                r_g1 <= pop_rdata[SW +: GW];
            end
            S_P2: begin
                r_s2 <= pop_rdata[SW-1:0];
                r_g2 <= pop_rdata[SW +: GW];
                if (pop_rdata[SW-1:0] == r_s1) r_res.status <= mpu_pkg::ST_REDRAW;
            end
            S_R1: r_row1 <= row_now;
            S_R2: begin
                r_row2 <= row_now;
                r_cnt  <= '0;
                r_acc  <= '0;
            end
            S_MAC: begin
                r_prod <= mac_prod;
                r_neg  <= r_cnt[2];
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt != '0) begin
                    if (r_neg) r_acc <= r_acc - mpu_pkg::ACC_W'(r_prod);
                    else r_acc <= r_acc + mpu_pkg::ACC_W'(r_prod);
                end
            end
            S_XMUL: r_x <= $signed({1'b0, r_scale}) * r_acc;
            S_WB: begin
                r_res <= '{status: mpu_pkg::ST_UPDATED,
                           changed_index: first_wins ? r_item.first_index
                                                     : r_item.second_index,
                           new_strategy: win_s,
                           strategy_total: n_tot[win_s],
                           fixated: r_res.fixated};
            end
            S_DONE: begin
                if (out_free) begin
                    r_out <= '{status: r_res.status, changed_index: r_res.changed_index,
                               new_strategy: r_res.new_strategy,
                               strategy_total: r_res.strategy_total, fixated: fix_now};
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // totals add up to the loaded count once a load has been counted
    a_tot_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |->
        ((13'(r_tot[0]) + 13'(r_tot[1]) + 13'(r_tot[2]) + 13'(r_tot[3]))
            == 13'(r_load_pos)))
        else $error("strategy totals disagree with load position");

    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");

    a_pop_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_we |-> (r_state == S_IDLE || r_state == S_WB))
        else $error("population write outside load or write-back");

    a_row_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_we |=> r_row_valid[$past(row_waddr)])
        else $error("group row written but not marked valid");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");
endmodule
`default_nettype wire

/* tb/moran_pairwise_update_step_test.sv */
`default_nettype none
module moran_pairwise_update_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpu_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 30;

    // Scoreboard: mirrors population, group rows and totals, and holds the
    // results that each accepted transfer must produce, oldest first.
    class moran_scoreboard;
        logic [63:0]  payoff_rows [4];
        int unsigned  scale;
        int unsigned  grp_size;
        logic [1:0]   member_strat [POP_MAX];
        int unsigned  member_group [POP_MAX];
        int unsigned  group_tally [MAX_GROUPS][MAX_STRAT];
        int unsigned  totals [MAX_STRAT];
        int unsigned  loaded;
        int unsigned  load_grp;
        int unsigned  grp_offset;
        int unsigned  copy_prob [LUT_DEPTH];
        t_out_item    pending_results [$];
        int           failures;

        function new();
            longint center;
            payoff_rows = '{default: 64'd0};
            scale = 256;
            grp_size = 2;
            loaded = 0;
            load_grp = 0;
            grp_offset = 0;
            failures = 0;
            foreach (group_tally[g, k]) group_tally[g][k] = 0;
            foreach (totals[k]) totals[k] = 0;
            for (int b = 0; b < LUT_DEPTH; b++) begin
                center = -longint'(HALF_RANGE)
                    + ((2 * longint'(b) + 1) * longint'(HALF_RANGE)) / LUT_DEPTH;
                copy_prob[b] = logistic_q16(center);
            end
        endfunction

        // Q0.16 logistic value at a Q16.16 point, via a truncated series
        // for exp(-|c|/16) raised to the 16th power.
        function int unsigned logistic_q16(longint c);
            longint unsigned mag, u, term, e, den, p;
            longint acc;
            mag  = (c < 0) ? longint'(-c) : longint'(c);
            u    = mag << 10;
            term = 64'd1 << 30;
            acc  = longint'(64'd1 << 30);
            for (int k = 1; k <= 10; k++) begin
                term = ((term * u) >> 30) / k;
                if (k % 2 == 1) acc = acc - longint'(term);
                else acc = acc + longint'(term);
            end
            e = longint'(acc);
            repeat (4) e = (e * e) >> 30;
            den = (64'd1 << 30) + e;
            p = ((e << 16) + den / 2) / den;
            return (c < 0) ? int'(65536 - p) : int'(p);
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                CFG_ROW0, CFG_ROW1, CFG_ROW2, CFG_ROW3: payoff_rows[idx] = value;
                CFG_SCALE: scale = value[15:0];
                CFG_GSIZE: grp_size = value[10:0];
                default: ;
            endcase
        endfunction

        function longint fitness(logic [1:0] s, int unsigned g);
            longint sum;
            int unsigned c;
            sum = 0;
            for (int k = 0; k < MAX_STRAT; k++) begin
                c = group_tally[g][k];
                if (k == s && c > 0) c--;
                sum += longint'(c) * longint'($signed(payoff_rows[s][16*k +: 16]));
            end
            return sum;
        endfunction

        function int unsigned prob_for(longint x);
            longint bin;
            if (x < -longint'(HALF_RANGE)) bin = 0;
            else if (x >= longint'(HALF_RANGE)) bin = LUT_DEPTH - 1;
            else bin = ((x + HALF_RANGE) * LUT_DEPTH) >>> 20;
            return copy_prob[bin];
        endfunction

        // Move one individual from strategy 'from' to 'to' inside group g.
        function void convert(int unsigned idx, logic [1:0] from, logic [1:0] to);
            int unsigned g;
            g = member_group[idx];
            if (totals[from] != 0) totals[from]--;
            totals[to]++;
            if (group_tally[g][from] != 0) group_tally[g][from]--;
            group_tally[g][to]++;
            member_strat[idx] = to;
        endfunction

        function void note_item(t_in_item it);
            t_out_item r;
            int unsigned gs, i1, i2;
            logic [1:0] s1, s2;
            longint x;
            r = '0;
            r.status = ST_RANGE;
            i1 = it.first_index;
            i2 = it.second_index;
            if (it.cmd == 1'b0) begin
                gs = (grp_size < 2) ? 2 : grp_size;
                if (loaded < POP_MAX && load_grp < MAX_GROUPS) begin
                    member_strat[loaded] = it.strategy;
                    member_group[loaded] = load_grp;
                    group_tally[load_grp][it.strategy]++;
                    totals[it.strategy]++;
                    r.status = ST_LOADED;
                    r.changed_index = loaded[9:0];
                    r.new_strategy = it.strategy;
                    r.strategy_total = totals[it.strategy][10:0];
                    loaded++;
                    grp_offset++;
                    if (grp_offset >= gs) begin
                        grp_offset = 0;
                        load_grp++;
                    end
                end
            end else if (i1 < loaded && i2 < loaded) begin
                s1 = member_strat[i1];
                s2 = member_strat[i2];
                if (s1 == s2) begin
                    r.status = ST_REDRAW;
                end else begin
                    x = longint'(scale) * (fitness(s1, member_group[i1])
                        - fitness(s2, member_group[i2]));
                    if (it.uniform_draw < prob_for(x)) begin
                        convert(i1, s1, s2);
                        r.changed_index = i1[9:0];
                        r.new_strategy = s2;
                    end else begin
                        convert(i2, s2, s1);
                        r.changed_index = i2[9:0];
                        r.new_strategy = s1;
                    end
                    r.status = ST_UPDATED;
                    r.strategy_total = totals[r.new_strategy][10:0];
                end
            end
            r.fixated = 1'b0;
            if (loaded != 0)
                foreach (totals[k]) if (totals[k] == loaded) r.fixated = 1'b1;
            pending_results.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.changed_index !== want.changed_index
                || got.new_strategy !== want.new_strategy
                || got.strategy_total !== want.strategy_total
                || got.fixated !== want.fixated) begin
                failures++;
                if (failures <= 10)
                    $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = CFG_ROW0;
    logic [63:0] i_cfg_data = '0;

    moran_scoreboard sb = new();
    int src_idle = 35;
    int dst_idle = 47;
    int quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    moran_pairwise_update_step u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Result side: check each transfer, then pick next cycle's stall.
    // Count cycles without any transfer; give up past the limit.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_result(o_out_data);
            quiet_cycles <= 0;
        end else if (i_rst_n && i_in_valid && o_in_stall === 1'b0) begin
            quiet_cycles <= 0;
        end else if (i_rst_n) begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        i_out_stall <= ($urandom_range(99) < dst_idle);
    end

    // Hold the item until the block takes it; record it for prediction.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < src_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_item(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all six registers on back-to-back edges, then drop the enable.
    task automatic program_regs(input logic [63:0] rows [4], input int scale,
                                input int gsize);
        logic [63:0] vals [6];
        vals[0] = rows[0];
        vals[1] = rows[1];
        vals[2] = rows[2];
        vals[3] = rows[3];
        vals[4] = 64'(scale);
        vals[5] = 64'(gsize);
        for (int r = 0; r < 6; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(r);
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            sb.write_reg(3'(r), vals[r]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item load_of(logic [1:0] s);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom});
        it.cmd = 1'b0;
        it.strategy = s;
        return it;
    endfunction

    function automatic t_in_item step_of(int a, int b, int draw);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom});
        it.cmd = 1'b1;
        it.first_index = 10'(a);
        it.second_index = 10'(b);
        it.uniform_draw = 16'(draw);
        return it;
    endfunction

    // Random payoff row; 16-bit fields within +/-mag, with occasional extremes.
    function automatic logic [63:0] rand_row(int mag);
        logic [63:0] row;
        int pick;
        for (int k = 0; k < 4; k++) begin
            pick = $urandom_range(99);
            if (pick < 5) row[16*k +: 16] = 16'h8000;
            else if (pick < 10) row[16*k +: 16] = 16'h7FFF;
            else row[16*k +: 16] = 16'($signed($urandom_range(2 * mag)) - mag);
        end
        return row;
    endfunction

    function automatic int pick_index();
        if (sb.loaded != 0 && $urandom_range(99) < 85)
            return $urandom_range(sb.loaded - 1);
        return $urandom_range(1023);
    endfunction

    initial begin
        logic [63:0] rows [4];
        int phase_items [3] = '{450, 500, 800};
        int load_pct [3] = '{10, 60, 95};
        int phase_gsize [3] = '{2, 16, 1024};
        int a, b, draw, pick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: payoff extremes, group size below two, every status.
        rows[0] = {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        rows[1] = {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001};
        rows[2] = rand_row(256);
        rows[3] = {4{16'h7FFF}};
        program_regs(rows, 65535, 1);
        send_item(step_of(0, 0, 0));           // empty population
        send_item(load_of(2'd0));
        send_item(load_of(2'd1));
        send_item(load_of(2'd2));
        send_item(load_of(2'd3));
        send_item(load_of(2'd0));
        send_item(load_of(2'd3));
        send_item(step_of(0, 0, 1234));        // same index twice
        send_item(step_of(0, 4, 777));         // same strategy
        send_item(step_of(1023, 0, 5));        // index out of range
        send_item(step_of(0, 1023, 5));
        send_item(step_of(6, 0, 5));           // index equal to loaded count
        send_item(step_of(0, 1, 0));
        send_item(step_of(2, 3, 65535));
        send_item(step_of(5, 1, 32768));
        send_item(step_of(1, 2, $urandom_range(65535)));
        drain();
        program_regs(rows, 0, 0);              // zero selection, group size zero
        send_item(load_of(2'd1));
        send_item(step_of(0, 2, 0));
        send_item(step_of(3, 1, 65535));
        send_item(step_of(4, 6, 32767));
        drain();

        for (int p = 0; p < 3; p++) begin
            src_idle = (p == 0) ? 35 : (p == 1) ? 47 : 0;
            dst_idle = (p == 0) ? 47 : (p == 1) ? 35 : 0;
            for (int r = 0; r < 4; r++) rows[r] = rand_row((p == 0) ? 8 : (p == 1) ? 128 : 32767);
            program_regs(rows, (p == 0) ? 65535 : (p == 1) ? $urandom_range(16, 512) : 256,
                         phase_gsize[p]);
            for (int n = 0; n < phase_items[p]; n++) begin
                pick = $urandom_range(99);
                if (pick < ((sb.loaded >= POP_MAX) ? 15 : load_pct[p])) begin
                    send_item(load_of(2'($urandom_range(3))));
                end else begin
                    a = pick_index();
                    b = ($urandom_range(99) < 5) ? a : pick_index();
                    pick = $urandom_range(99);
                    draw = (pick < 5) ? 0 : (pick < 10) ? 65535 : $urandom_range(65535);
                    send_item(step_of(a, b, draw));
                end
            end
            drain();
        end

        if (sb.failures == 0 && sb.pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
